/* design/swpr_pkg.sv */
// Shared widths, constants and control/status types for the sliding window
// packet receiver. No dependencies; all files but swpr_ram refer to it by scoped name.
`default_nettype none

package swpr_pkg;

   localparam int FUNC_W   = 1;
   localparam int ID_W     = 32;
   localparam int LEN_W    = 10;
   localparam int HEAD_W   = 40;
   localparam int SLOT_W   = 6;

   localparam int WINDOW_DEF      = 64;
   localparam int MAX_PAYLOAD_DEF = 512;

   // "*EOF*" with the first byte in the top bits
   localparam logic [HEAD_W-1:0] END_MARK = 40'h2A454F462A;

   localparam logic [FUNC_W-1:0] FUNC_PACKET  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch the accepted request beat
      logic eval;         // classify, apply store, latch result header
      logic finish;       // close the window: advance base, clear slots
      logic off_clr;      // restart the flush walk
      logic off_inc;      // step the flush walk
      logic load_single;  // load a header-only result
      logic load_rel;     // load a release result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ack;
      logic done;
      logic flush;
      logic empty;        // no stored packets once the store is applied
      logic occ_hit;      // walk offset holds a stored packet
      logic rel_last;     // next release is the final one
      logic out_free;     // result register can take a beat
   } status_type;

endpackage

`default_nettype wire

/* design/swpr_ifs.sv */
// Valid/ready channel interfaces for the request and response beats.
// Depends on swpr_pkg for the field widths.
`default_nettype none

interface swpr_req_if;
   logic                             valid;
   logic                             ready;
   logic [swpr_pkg::FUNC_W-1:0]      func;
   logic [swpr_pkg::ID_W-1:0]        packet_id;
   logic [swpr_pkg::LEN_W-1:0]       payload_length;
   logic [swpr_pkg::HEAD_W-1:0]      payload_head;

   modport source (output valid, func, packet_id, payload_length, payload_head,
                   input ready);
   modport sink   (input valid, func, packet_id, payload_length, payload_head,
                   output ready);
endinterface

interface swpr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             ack_valid;
   logic [swpr_pkg::ID_W-1:0]        ack_number;
   logic                             store_valid;
   logic [swpr_pkg::SLOT_W-1:0]      store_slot;
   logic                             release_valid;
   logic [swpr_pkg::SLOT_W-1:0]      release_slot;
   logic [swpr_pkg::ID_W-1:0]        release_id;
   logic [swpr_pkg::LEN_W-1:0]       release_length;
   logic                             done_res;
   logic                             last;

   modport source (output valid, ack_valid, ack_number, store_valid, store_slot,
                   release_valid, release_slot, release_id, release_length,
                   done_res, last,
                   input ready);
   modport sink   (input valid, ack_valid, ack_number, store_valid, store_slot,
                   release_valid, release_slot, release_id, release_length,
                   done_res, last,
                   output ready);
endinterface

`default_nettype wire

/* design/swpr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/swpr_ctrl.sv */
// Sequencer for the receiver: accept, evaluate, header-only result, flush walk.
// Depends on swpr_pkg for the command and status structs.
`default_nettype none

module swpr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire swpr_pkg::status_type st,
   output swpr_pkg::cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EVAL   = 5'b00010,
      S_SINGLE = 5'b00100,
      S_SCAN   = 5'b01000,
      S_LOAD   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (st.flush) begin
               if (st.empty) begin
                  cmd.finish = 1'b1;
                  state_in   = (st.ack || st.done) ? S_SINGLE : S_IDLE;
               end else begin
                  cmd.off_clr = 1'b1;
                  state_in    = S_SCAN;
               end
            end else begin
               state_in = st.ack ? S_SINGLE : S_IDLE;
            end
         end
         S_SINGLE: begin
            if (st.out_free) begin
               cmd.load_single = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SCAN: begin
            // a hit has its RAM read under way; the data is there next cycle
            if (st.occ_hit) begin
               state_in = S_LOAD;
            end else begin
               cmd.off_inc = 1'b1;
            end
         end
         S_LOAD: begin
            if (st.out_free) begin
               cmd.load_rel = 1'b1;
               cmd.off_inc  = 1'b1;
               if (st.rel_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/swpr_dp.sv */
// Receiver datapath: window base, fill count, per-offset occupancy flags,
// offset-indexed slot/length RAM, flush walk counters and the result register.
// Depends on swpr_pkg, swpr_ifs (response channel) and swpr_ram.
`default_nettype none

module swpr_dp #(
   parameter int WINDOW      = swpr_pkg::WINDOW_DEF,
   parameter int MAX_PAYLOAD = swpr_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [swpr_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [swpr_pkg::ID_W-1:0]      req_packet_id,
   input  wire logic [swpr_pkg::LEN_W-1:0]     req_payload_length,
   input  wire logic [swpr_pkg::HEAD_W-1:0]    req_payload_head,
   input  wire swpr_pkg::cmd_type              cmd,
   output swpr_pkg::status_type                st,
   swpr_rsp_if.source                          rsp_bus
);

   localparam int OFF_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int ID_W   = swpr_pkg::ID_W;
   localparam int LEN_W  = swpr_pkg::LEN_W;
   localparam int SLOT_W = swpr_pkg::SLOT_W;
   localparam int RAM_W  = SLOT_W + LEN_W;

   // latched request beat
   logic [swpr_pkg::FUNC_W-1:0] in_func_ff;
   logic [ID_W-1:0]             in_id_ff;
   logic [LEN_W-1:0]            in_len_ff;
   logic [swpr_pkg::HEAD_W-1:0] in_head_ff;

   // window state
   logic [ID_W-1:0]   base_ff, base_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              finished_ff, finished_in;
   logic [WINDOW-1:0] occ_ff, occ_in;

   // flush walk
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [FILL_W-1:0] rel_cnt_ff, rel_cnt_in;

   // result header, latched at evaluation
   logic              hdr_ack_ff;
   logic [ID_W-1:0]   ack_num_ff;
   logic              hdr_store_ff;
   logic [SLOT_W-1:0] store_slot_ff;
   logic              done_ff;
   logic              first_ff, first_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              o_ack_valid_ff;
   logic [ID_W-1:0]   o_ack_number_ff;
   logic              o_store_valid_ff;
   logic [SLOT_W-1:0] o_store_slot_ff;
   logic              o_rel_valid_ff;
   logic [SLOT_W-1:0] o_rel_slot_ff;
   logic [ID_W-1:0]   o_rel_id_ff;
   logic [LEN_W-1:0]  o_rel_len_ff;
   logic              o_done_ff;
   logic              o_last_ff;

   // classification
   logic [ID_W-1:0]   diff;
   logic [OFF_W-1:0]  off;
   logic              below, in_win, dup, is_new, is_pkt, eof;
   logic              do_ack, do_store, do_done, do_flush;
   logic [FILL_W-1:0] fill_after;
   logic [LEN_W-1:0]  len_sat;
   logic              out_free, load, done_now;

   logic              ram_wr_en;
   logic [RAM_W-1:0]  ram_wr_data, ram_rd_data;
   logic [SLOT_W-1:0] rd_slot;
   logic [LEN_W-1:0]  rd_len;

   always_comb begin
      diff     = in_id_ff - base_ff;
      below    = in_id_ff < base_ff;
      // window never wraps: an id past the top of the range is above it
      in_win   = !below && (diff < ID_W'(WINDOW));
      off      = diff[OFF_W-1:0];
      dup      = in_win && occ_ff[off];
      is_new   = in_win && !dup;
      is_pkt   = !finished_ff && (in_func_ff == swpr_pkg::FUNC_PACKET);
      eof      = is_new && (in_head_ff == swpr_pkg::END_MARK);
      do_ack   = is_pkt && (in_win || below);
      do_done  = is_pkt && eof;
      do_store = is_pkt && is_new && !eof;
      fill_after = fill_ff + FILL_W'(do_store);
      do_flush = !finished_ff && ((in_func_ff == swpr_pkg::FUNC_TIMEOUT) || do_done ||
                                  (do_store && (fill_after == FILL_W'(WINDOW))));
      len_sat  = (ID_W'(in_len_ff) > ID_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : in_len_ff;
   end

   assign ram_wr_en   = cmd.eval && do_store;
   assign ram_wr_data = {SLOT_W'(fill_ff), len_sat};
   assign rd_slot     = ram_rd_data[RAM_W-1:LEN_W];
   assign rd_len      = ram_rd_data[LEN_W-1:0];

   swpr_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (off),
      .wr_data (ram_wr_data),
      .rd_addr (off_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign load     = cmd.load_single || cmd.load_rel;
   assign done_now = cmd.eval ? do_done : done_ff;

   always_comb begin
      st.ack      = do_ack;
      st.done     = do_done;
      st.flush    = do_flush;
      st.empty    = (fill_after == '0);
      st.occ_hit  = occ_ff[off_ff];
      st.rel_last = ((rel_cnt_ff + FILL_W'(1)) == fill_ff);
      st.out_free = out_free;
   end

   // window state, flush walk, first-result flag and output valid next values
   always_comb begin
      base_in     = base_ff;
      fill_in     = fill_ff;
      finished_in = finished_ff;
      occ_in      = occ_ff;
      if (cmd.finish) begin
         base_in     = base_ff + ID_W'(WINDOW);
         fill_in     = '0;
         occ_in      = '0;
         finished_in = finished_ff || done_now;
      end else if (cmd.eval) begin
         fill_in = fill_after;
         if (do_store) begin
            occ_in[off] = 1'b1;
         end
      end

      off_in     = off_ff;
      rel_cnt_in = rel_cnt_ff;
      if (cmd.off_clr) begin
         off_in     = '0;
         rel_cnt_in = '0;
      end else begin
         if (cmd.off_inc) begin
            off_in = off_ff + OFF_W'(1);
         end
         if (cmd.load_rel) begin
            rel_cnt_in = rel_cnt_ff + FILL_W'(1);
         end
      end

      first_in = first_ff;
      if (cmd.eval) begin
         first_in = 1'b1;
      end else if (load) begin
         first_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         fill_ff      <= '0;
         finished_ff  <= 1'b0;
         occ_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         fill_ff      <= fill_in;
         finished_ff  <= finished_in;
         occ_ff       <= occ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      rel_cnt_ff <= rel_cnt_in;
      first_ff   <= first_in;

      if (cmd.capture) begin
         in_func_ff <= req_func;
         in_id_ff   <= req_packet_id;
         in_len_ff  <= req_payload_length;
         in_head_ff <= req_payload_head;
      end

      if (cmd.eval) begin
         hdr_ack_ff    <= do_ack;
         ack_num_ff    <= do_ack ? in_id_ff + ID_W'(1) : '0;
         hdr_store_ff  <= do_store;
         store_slot_ff <= do_store ? SLOT_W'(fill_ff) : '0;
         done_ff       <= do_done;
      end

      if (load) begin
         o_ack_valid_ff   <= first_ff && hdr_ack_ff;
         o_ack_number_ff  <= first_ff ? ack_num_ff : '0;
         o_store_valid_ff <= first_ff && hdr_store_ff;
         o_store_slot_ff  <= first_ff ? store_slot_ff : '0;
         o_rel_valid_ff   <= cmd.load_rel;
         o_rel_slot_ff    <= cmd.load_rel ? rd_slot : '0;
         o_rel_id_ff      <= cmd.load_rel ? base_ff + ID_W'(off_ff) : '0;
         o_rel_len_ff     <= cmd.load_rel ? rd_len : '0;
         o_done_ff        <= done_ff;
         o_last_ff        <= cmd.load_single || st.rel_last;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.ack_valid      = o_ack_valid_ff;
   assign rsp_bus.ack_number     = o_ack_number_ff;
   assign rsp_bus.store_valid    = o_store_valid_ff;
   assign rsp_bus.store_slot     = o_store_slot_ff;
   assign rsp_bus.release_valid  = o_rel_valid_ff;
   assign rsp_bus.release_slot   = o_rel_slot_ff;
   assign rsp_bus.release_id     = o_rel_id_ff;
   assign rsp_bus.release_length = o_rel_len_ff;
   assign rsp_bus.done_res       = o_done_ff;
   assign rsp_bus.last           = o_last_ff;

endmodule

`default_nettype wire

/* design/sliding_window_packet_receiver.sv */
// Top level of the selective-repeat receive window controller.
// Depends on swpr_pkg, swpr_ifs, swpr_ctrl, swpr_dp (and swpr_ram below it).
//
// Each request beat is a packet arrival or a timeout tick. It is accepted in
// S_IDLE, evaluated in S_EVAL and, if it gives a response, loaded into the
// result register. A beat that only acknowledges or stores loads its response
// in S_SINGLE once the result register is free, and the next request is
// taken when the sequencer is back in S_IDLE. A beat that gives no response
// frees the input straight after S_EVAL. A flush walks the window offsets
// from the base, one offset per cycle while no packet is stored there; a
// stored packet takes an extra S_LOAD step for the registered read of the
// offset-indexed slot RAM, and waits there while the result register is not
// free. A flush ends at the last stored packet. Duplicate detection uses one
// occupancy flag per window offset, so there is no clearing pass after reset.
// Requests are taken only while the sequencer is idle; a finished response
// waits in its output register while the next request is accepted.
`default_nettype none

module sliding_window_packet_receiver #(
   parameter int WINDOW      = swpr_pkg::WINDOW_DEF,
   parameter int MAX_PAYLOAD = swpr_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   swpr_req_if.sink   req_bus,
   swpr_rsp_if.source rsp_bus
);

   swpr_pkg::cmd_type    cmd;
   swpr_pkg::status_type st;
   logic                 req_ready;

   assign req_bus.ready = req_ready;

   swpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   swpr_dp #(
      .WINDOW      (WINDOW),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_bus.func),
      .req_packet_id      (req_bus.packet_id),
      .req_payload_length (req_bus.payload_length),
      .req_payload_head   (req_bus.payload_head),
      .cmd                (cmd),
      .st                 (st),
      .rsp_bus            (rsp_bus)
   );

endmodule

`default_nettype wire
